@@ sv/mp2s_pkg.sv @@
// ----------------------------------------------------------------------------
// mp2s_pkg
// Register map, register widths and reset values of the 2x2 max pooling block.
// ----------------------------------------------------------------------------
package mp2s_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_MAP_ROWS     = 2'd0;
  localparam logic [1:0] REG_MAP_COLS     = 2'd1;
  localparam logic [1:0] REG_MAP_CHANNELS = 2'd2;

  localparam int ROWS_REG_W  = 13;
  localparam int COLS_REG_W  = 9;
  localparam int CHANS_REG_W = 6;
  localparam int ROW_POS_W   = 12;

  localparam logic [ROWS_REG_W-1:0]  ROW_LIMIT      = 13'd4096;
  localparam logic [ROWS_REG_W-1:0]  ROWS_RESET     = 13'd150;
  localparam logic [COLS_REG_W-1:0]  COLS_RESET     = 9'd150;
  localparam logic [CHANS_REG_W-1:0] CHANNELS_RESET = 6'd32;

endpackage

@@ sv/mp2s_ram.sv @@
// ----------------------------------------------------------------------------
// mp2s_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mp2s_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/max_pool_2x2_stream.sv @@
// ----------------------------------------------------------------------------
// max_pool_2x2_stream
// Streaming 2x2 max pooling, stride 2, valid padding, signed fixed point.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | tdata: pixel_value
//  m_axis   | out | tdata: pooled_value, tlast: last_of_map
//  apb      | in  | map_rows @0x0, map_cols @0x4, map_channels @0x8
//
//  One input beat per cycle while the output is not stalled; a result passes
//  through the compute stage and the output register. The line store is read
//  on input accept and written when the compute stage advances; the raster
//  order keeps a read and the write to the same entry at least two beats apart.
//  Reset clears positions and valids and loads the configuration registers
//  with their reset values; the stores need no clearing. An output stall holds
//  the compute stage, which then holds input.
module max_pool_2x2_stream #(
  parameter int MAX_COLS     = 256,
  parameter int MAX_CHANNELS = 32,
  parameter int DATA_BITS    = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((DATA_BITS + 7) / 8) * 8-1:0]    s_axis_tdata,  // pixel_value
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((DATA_BITS + 7) / 8) * 8-1:0]    m_axis_tdata,  // pooled_value
  output logic                                    m_axis_tlast,  // last_of_map
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [mp2s_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [mp2s_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [mp2s_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int TdataW    = ((DATA_BITS + 7) / 8) * 8;
  localparam int ColPosW   = $clog2(MAX_COLS);
  localparam int ColW      = ColPosW + 1;
  localparam int ChanPosW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ChanW     = ChanPosW + 1;
  localparam int ColCmpW   = (ColW > mp2s_pkg::COLS_REG_W) ? ColW : mp2s_pkg::COLS_REG_W;
  localparam int ChanCmpW  = (ChanW > mp2s_pkg::CHANS_REG_W) ? ChanW : mp2s_pkg::CHANS_REG_W;
  localparam int PairSlots = (MAX_COLS + 1) / 2;
  localparam int LineDepth = PairSlots * MAX_CHANNELS;
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int RowsW     = mp2s_pkg::ROWS_REG_W;

  function automatic logic [DATA_BITS-1:0] smax(logic [DATA_BITS-1:0] a,
                                                logic [DATA_BITS-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // Configuration registers
  logic [RowsW-1:0]                   map_rows_q;
  logic [mp2s_pkg::COLS_REG_W-1:0]    map_cols_q;
  logic [mp2s_pkg::CHANS_REG_W-1:0]   map_channels_q;
  logic                               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q     <= mp2s_pkg::ROWS_RESET;
      map_cols_q     <= mp2s_pkg::COLS_RESET;
      map_channels_q <= mp2s_pkg::CHANNELS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mp2s_pkg::REG_MAP_ROWS:     map_rows_q     <= pwdata[RowsW-1:0];
        mp2s_pkg::REG_MAP_COLS:     map_cols_q     <= pwdata[mp2s_pkg::COLS_REG_W-1:0];
        mp2s_pkg::REG_MAP_CHANNELS: map_channels_q <= pwdata[mp2s_pkg::CHANS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      mp2s_pkg::REG_MAP_ROWS:     prdata = mp2s_pkg::APB_DATA_W'(map_rows_q);
      mp2s_pkg::REG_MAP_COLS:     prdata = mp2s_pkg::APB_DATA_W'(map_cols_q);
      mp2s_pkg::REG_MAP_CHANNELS: prdata = mp2s_pkg::APB_DATA_W'(map_channels_q);
      default:                    prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, saturate at the maximum
  logic [RowsW-1:0]    rows_eff;
  logic [ColCmpW-1:0]  cols_ext;
  logic [ColW-1:0]     cols_eff;
  logic [ChanCmpW-1:0] chans_ext;
  logic [ChanW-1:0]    chans_eff;

  assign cols_ext  = ColCmpW'(map_cols_q);
  assign chans_ext = ChanCmpW'(map_channels_q);

  always_comb begin
    if (map_rows_q == '0) begin
      rows_eff = RowsW'(1);
    end else if (map_rows_q > mp2s_pkg::ROW_LIMIT) begin
      rows_eff = mp2s_pkg::ROW_LIMIT;
    end else begin
      rows_eff = map_rows_q;
    end
    if (cols_ext == '0) begin
      cols_eff = ColW'(1);
    end else if (cols_ext > ColCmpW'(MAX_COLS)) begin
      cols_eff = ColW'(MAX_COLS);
    end else begin
      cols_eff = ColW'(cols_ext);
    end
    if (chans_ext == '0) begin
      chans_eff = ChanW'(1);
    end else if (chans_ext > ChanCmpW'(MAX_CHANNELS)) begin
      chans_eff = ChanW'(MAX_CHANNELS);
    end else begin
      chans_eff = ChanW'(chans_ext);
    end
  end

  // Raster position
  logic [mp2s_pkg::ROW_POS_W-1:0] row_q;
  logic [ColPosW-1:0]             col_q;
  logic [ChanPosW-1:0]            chan_q;
  logic [RowsW-1:0]               row_inc;
  logic [ColW-1:0]                col_inc;
  logic [ChanW-1:0]               chan_inc;
  logic                           row_wrap;
  logic                           col_wrap;
  logic                           chan_wrap;
  logic                           s_fire;

  assign row_inc   = RowsW'(row_q) + RowsW'(1);
  assign col_inc   = ColW'(col_q) + ColW'(1);
  assign chan_inc  = ChanW'(chan_q) + ChanW'(1);
  assign row_wrap  = row_inc >= rows_eff;
  assign col_wrap  = col_inc >= cols_eff;
  assign chan_wrap = chan_inc >= chans_eff;
  assign s_fire    = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      chan_q <= '0;
    end else if (s_fire) begin
      if (chan_wrap) begin
        chan_q <= '0;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_inc[mp2s_pkg::ROW_POS_W-1:0];
        end else begin
          col_q <= col_inc[ColPosW-1:0];
        end
      end else begin
        chan_q <= chan_inc[ChanPosW-1:0];
      end
    end
  end

  // Column pair hold
  logic [DATA_BITS-1:0] pix;
  logic                 odd_col;
  logic                 odd_row;
  logic                 map_last;
  logic [RowsW-1:0]     rows_even;
  logic [ColW-1:0]      cols_even;
  logic                 hold_we;
  logic                 hold_re;
  logic [DATA_BITS-1:0] hold_rdata;

  assign pix       = s_axis_tdata[DATA_BITS-1:0];
  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign rows_even = {rows_eff[RowsW-1:1], 1'b0};
  assign cols_even = {cols_eff[ColW-1:1], 1'b0};
  assign map_last  = (row_inc >= rows_even) && (col_inc >= cols_even) && chan_wrap;
  assign hold_we   = s_fire & ~odd_col;
  assign hold_re   = s_fire & odd_col;

  mp2s_ram #(
    .Width (DATA_BITS),
    .Depth (MAX_CHANNELS)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (hold_we),
    .waddr_i (chan_q),
    .wdata_i (pix),
    .re_i    (hold_re),
    .raddr_i (chan_q),
    .rdata_o (hold_rdata)
  );

  // Line store
  logic [AddrW-1:0]     slot;
  logic                 ram_re;
  logic                 ram_we;
  logic [DATA_BITS-1:0] ram_rdata;

  assign slot   = AddrW'(col_q >> 1) * AddrW'(MAX_CHANNELS) + AddrW'(chan_q);
  assign ram_re = s_fire & odd_col & odd_row;

  // Compute stage
  logic                 s1_valid_q;
  logic                 s1_wr_q;
  logic                 s1_out_q;
  logic                 s1_last_q;
  logic [DATA_BITS-1:0] s1_pix_q;
  logic [AddrW-1:0]     s1_addr_q;
  logic [DATA_BITS-1:0] pair_max;
  logic                 s1_adv;
  logic                 out_valid_q;
  logic                 out_last_q;
  logic [DATA_BITS-1:0] out_data_q;
  logic                 out_load;

  assign pair_max      = smax(hold_rdata, s1_pix_q);
  assign s1_adv        = s1_valid_q & (~s1_out_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign ram_we        = s1_adv & s1_wr_q;
  assign out_load      = s1_adv & s1_out_q;

  mp2s_ram #(
    .Width (DATA_BITS),
    .Depth (LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (pair_max),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_wr_q    <= 1'b0;
      s1_out_q   <= 1'b0;
    end else if (s_fire) begin
      s1_valid_q <= 1'b1;
      s1_wr_q    <= odd_col & ~odd_row;
      s1_out_q   <= odd_col & odd_row;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      s1_wr_q    <= 1'b0;
      s1_out_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_pix_q  <= pix;
      s1_addr_q <= slot;
      s1_last_q <= map_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= smax(ram_rdata, pair_max);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'(out_data_q);
  assign m_axis_tlast  = out_last_q;

  a_fire_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> s1_valid_q)
    else $error("accepted beat did not reach the compute stage");

  a_no_read_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !ram_re)
    else $error("line store read while compute stage stalled");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (s1_addr_q != slot))
    else $error("line store read and write hit the same entry");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("pooled beat lost on the way to the output register");

endmodule
